// ===== rtl/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// Streebog engine package
// Shared types, the S-box, the linear map, the round constants and the LPS
// transform of GOST R 34.11-2012.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int unsigned ROUNDS = 12;
  localparam int unsigned RC_W   = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY0,
    ST_RS,
    ST_RK,
    ST_FIN,
    ST_PAD,
    ST_DIG
  } state_t;

  // Which compression is running.
  typedef enum logic [1:0] {
    PH_BLOCK,
    PH_LAST,
    PH_NSUM,
    PH_SSUM
  } phase_t;

  typedef struct packed {
    logic              accept;
    phase_t            phase;
    logic [RC_W-1:0]   rc;
    logic              key0;
    logic              rstep;
    logic              kstep;
    logic              fin;
    logic              pad;
    logic              add_go;
    logic              dig_load;
  } ctl_t;

  typedef struct packed {
    logic wh7;
    logic vfull;
    logic out_busy;
  } stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
    8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
    8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
    8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
    8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
    8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
    8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
    8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
    8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
    8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
    8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
    8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
    8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
    8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
    8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
    8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
    8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
    8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
    8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
    8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
    8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
    8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
    8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
    8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
    8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
    8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
    8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
    8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
    8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
    8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
    8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
    8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
  };

  // Rows of the linear map; row 0 belongs to the most significant bit.
  localparam logic [63:0] LMAT [64] = '{
    64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
    64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
    64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
    64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
    64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
    64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
    64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
    64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
    64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
    64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
    64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
    64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
    64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
    64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
    64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
    64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
  };

  // Round constant C_(r+1), word 7 first in the concatenation.
  function automatic logic [511:0] rconst(input logic [RC_W-1:0] r);
    logic [511:0] c;
    case (r)
      4'd0: c = {64'hB1085BDA1ECADAE9,64'hEBCB2F81C0657C1F,64'h2F6A76432E45D016,
                 64'h714EB88D7585C4FC,64'h4B7CE09192676901,64'hA2422A08A460D315,
                 64'h05767436CC744D23,64'hDD806559F2A64507};
      4'd1: c = {64'h6FA3B58AA99D2F1A,64'h4FE39D460F70B5D7,64'hF3FEEA720A232B98,
                 64'h61D55E0F16B50131,64'h9AB5176B12D69958,64'h5CB561C2DB0AA7CA,
                 64'h55DDA21BD7CBCD56,64'hE679047021B19BB7};
      4'd2: c = {64'hF574DCAC2BCE2FC7,64'h0A39FC286A3D8435,64'h06F15E5F529C1F8B,
                 64'hF2EA7514B1297B7B,64'hD3E20FE490359EB1,64'hC1C93A376062DB09,
                 64'hC2B6F443867ADB31,64'h991E96F50ABA0AB2};
      4'd3: c = {64'hEF1FDFB3E81566D2,64'hF948E1A05D71E4DD,64'h488E857E335C3C7D,
                 64'h9D721CAD685E353F,64'hA9D72C82ED03D675,64'hD8B71333935203BE,
                 64'h3453EAA193E837F1,64'h220CBEBC84E3D12E};
      4'd4: c = {64'h4BEA6BACAD474799,64'h9A3F410C6CA92363,64'h7F151C1F1686104A,
                 64'h359E35D7800FFFBD,64'hBFCD1747253AF5A3,64'hDFFF00B723271A16,
                 64'h7A56A27EA9EA63F5,64'h601758FD7C6CFE57};
      4'd5: c = {64'hAE4FAEAE1D3AD3D9,64'h6FA4C33B7A3039C0,64'h2D66C4F95142A46C,
                 64'h187F9AB49AF08EC6,64'hCFFAA6B71C9AB7B4,64'h0AF21F66C2BEC6B6,
                 64'hBF71C57236904F35,64'hFA68407A46647D6E};
      4'd6: c = {64'hF4C70E16EEAAC5EC,64'h51AC86FEBF240954,64'h399EC6C7E6BF87C9,
                 64'hD3473E33197A93C9,64'h0992ABC52D822C37,64'h06476983284A0504,
                 64'h3517454CA23C4AF3,64'h8886564D3A14D493};
      4'd7: c = {64'h9B1F5B424D93C9A7,64'h03E7AA020C6E4141,64'h4EB7F8719C36DE1E,
                 64'h89B4443B4DDBC49A,64'hF4892BCB929B0690,64'h69D18D2BD1A5C42F,
                 64'h36ACC2355951A8D9,64'hA47F0DD4BF02E71E};
      4'd8: c = {64'h378F5A541631229B,64'h944C9AD8EC165FDE,64'h3A7D3A1B25894224,
                 64'h3CD955B7E00D0984,64'h800A440BDBB2CEB1,64'h7B2B8A9AA6079C54,
                 64'h0E38DC92CB1F2A60,64'h7261445183235ADB};
      4'd9: c = {64'hABBEDEA680056F52,64'h382AE548B2E4F3F3,64'h8941E71CFF8A78DB,
                 64'h1FFFE18A1B336103,64'h9FE76702AF69334B,64'h7A1E6C303B7652F4,
                 64'h3698FAD1153BB6C3,64'h74B4C7FB98459CED};
      4'd10: c = {64'h7BCD9ED0EFC889FB,64'h3002C6CD635AFE94,64'hD8FA6BBBEBAB0761,
                  64'h2001802114846679,64'h8A1D71EFEA48B9CA,64'hEFBACD1D7D476E98,
                  64'hDEA2594AC06FD85D,64'h6BCAA4CD81F32D1B};
      4'd11: c = {64'h378EE767F11631BA,64'hD21380B00449B17A,64'hCDA43C32BCDF1D77,
                  64'hF82012D430219F9B,64'h5D80EF9D1891CC86,64'hE71DA4AA88E12852,
                  64'hFAF417D5D9B21B99,64'h48BC924AF11BD720};
      default: c = '0;
    endcase
    return c;
  endfunction

  // Substitution, byte transposition and the linear map on a 512-bit state.
  function automatic logic [511:0] lps(input logic [511:0] s);
    logic [63:0]  w;
    logic [63:0]  r;
    logic [511:0] t;
    for (int k = 0; k < 8; k++) begin
      w = '0;
      for (int b = 0; b < 8; b++) begin
        w[8*b +: 8] = SBOX[s[64*b + 8*k +: 8]];
      end
      r = '0;
      for (int j = 0; j < 64; j++) begin
        if (w[j]) begin
          r = r ^ LMAT[63-j];
        end
      end
      t[64*k +: 64] = r;
    end
    return t;
  endfunction

endpackage

// ===== rtl/stb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Streebog engine controller
// Sequences word intake, the compression rounds, padding and digest load.
// ----------------------------------------------------------------------------
module stb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last_word,
  output logic           in_stall,
  input  stb_pkg::stat_t stat,
  output stb_pkg::ctl_t  ctl
);

  stb_pkg::state_t               state_r, state_nxt;
  stb_pkg::phase_t               phase_r, phase_nxt;
  logic [stb_pkg::RC_W-1:0]      rc_r, rc_nxt;
  logic                          pad_pend_r, pad_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= stb_pkg::ST_IDLE;
      phase_r    <= stb_pkg::PH_BLOCK;
      rc_r       <= '0;
      pad_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      rc_r       <= rc_nxt;
      pad_pend_r <= pad_pend_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    rc_nxt       = rc_r;
    pad_pend_nxt = pad_pend_r;
    ctl          = '0;
    ctl.phase    = phase_r;
    ctl.rc       = rc_r;
    in_stall     = (state_r != stb_pkg::ST_IDLE);
    case (state_r)
      stb_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (!in_last_word) begin
            if (stat.wh7) begin
              phase_nxt    = stb_pkg::PH_BLOCK;
              pad_pend_nxt = 1'b0;
              state_nxt    = stb_pkg::ST_KEY0;
            end
          end else if (stat.wh7 && stat.vfull) begin
            // A full last word closes a block; padding follows in a block of its own.
            phase_nxt    = stb_pkg::PH_BLOCK;
            pad_pend_nxt = 1'b1;
            state_nxt    = stb_pkg::ST_KEY0;
          end else begin
            phase_nxt = stb_pkg::PH_LAST;
            state_nxt = stb_pkg::ST_KEY0;
          end
        end
      end
      stb_pkg::ST_KEY0: begin
        ctl.key0   = 1'b1;
        ctl.add_go = (phase_r == stb_pkg::PH_BLOCK) || (phase_r == stb_pkg::PH_LAST);
        rc_nxt     = '0;
        state_nxt  = stb_pkg::ST_RS;
      end
      stb_pkg::ST_RS: begin
        ctl.rstep = 1'b1;
        state_nxt = stb_pkg::ST_RK;
      end
      stb_pkg::ST_RK: begin
        ctl.kstep = 1'b1;
        if (rc_r == stb_pkg::RC_W'(stb_pkg::ROUNDS - 1)) begin
          state_nxt = stb_pkg::ST_FIN;
        end else begin
          rc_nxt    = rc_r + 1'b1;
          state_nxt = stb_pkg::ST_RS;
        end
      end
      stb_pkg::ST_FIN: begin
        ctl.fin = 1'b1;
        case (phase_r)
          stb_pkg::PH_BLOCK: begin
            state_nxt = pad_pend_r ? stb_pkg::ST_PAD : stb_pkg::ST_IDLE;
          end
          stb_pkg::PH_LAST: begin
            phase_nxt = stb_pkg::PH_NSUM;
            state_nxt = stb_pkg::ST_KEY0;
          end
          stb_pkg::PH_NSUM: begin
            phase_nxt = stb_pkg::PH_SSUM;
            state_nxt = stb_pkg::ST_KEY0;
          end
          default: begin
            state_nxt = stb_pkg::ST_DIG;
          end
        endcase
      end
      stb_pkg::ST_PAD: begin
        ctl.pad      = 1'b1;
        pad_pend_nxt = 1'b0;
        phase_nxt    = stb_pkg::PH_LAST;
        state_nxt    = stb_pkg::ST_KEY0;
      end
      stb_pkg::ST_DIG: begin
        if (!stat.out_busy) begin
          ctl.dig_load = 1'b1;
          state_nxt    = stb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/stb_datapath.sv =====
// ----------------------------------------------------------------------------
// Streebog engine datapath
// Message block, chain value, counter and checksum registers, the shared LPS
// unit, the word-serial 512-bit adders and the digest output buffer.
// ----------------------------------------------------------------------------
module stb_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic           cfg_wr_data,
  input  logic [63:0]    in_data_word,
  input  logic [6:0]     in_valid_bits,
  input  logic           in_last_word,
  input  stb_pkg::ctl_t  ctl,
  output stb_pkg::stat_t stat,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [63:0]    out_digest_word,
  output logic           out_last_out
);

  localparam logic [6:0] FULL_BITS = 7'd64;
  localparam logic [9:0] BLK_BITS  = 10'd512;

  // Control registers.
  logic        mode_r, mode_nxt;
  logic        dig_mode_r, dig_mode_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [2:0]  wh_r, wh_nxt;
  logic        add_busy_r, add_busy_nxt;
  logic [2:0]  add_idx_r, add_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;

  // Payload registers.
  logic [511:0] m_r, m_nxt;
  logic [511:0] h_r, h_nxt;
  logic [511:0] n_r, n_nxt;
  logic [511:0] sig_r, sig_nxt;
  logic [511:0] key_r, key_nxt;
  logic [511:0] st_r, st_nxt;
  logic [511:0] dig_r, dig_nxt;
  logic [9:0]   len_r, len_nxt;
  logic [9:0]   add_len_r, add_len_nxt;
  logic         cn_r, cn_nxt;
  logic         cs_r, cs_nxt;

  logic [6:0]   v_sat;
  logic [511:0] n_sel;
  logic [511:0] m_sel;
  logic [511:0] lps_in;
  logic [511:0] lps_out;
  logic [64:0]  n_sum;
  logic [64:0]  s_sum;
  logic [63:0]  n_add;

  // Pads the block: words below nw stay, word nw gets the pad bit above v bits.
  function automatic logic [511:0] pad_block(input logic [511:0] m, input logic [2:0] nw,
                                             input logic [6:0] v, input logic [63:0] w);
    logic [511:0] r;
    logic [63:0]  bit1;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < {1'b0, nw}) begin
        r[64*i +: 64] = m[64*i +: 64];
      end else if (4'(i) == {1'b0, nw}) begin
        bit1 = 64'd1 << v[5:0];
        r[64*i +: 64] = v[6] ? w : ((w & (bit1 - 64'd1)) | bit1);
      end else if ((4'(i) == ({1'b0, nw} + 4'd1)) && v[6]) begin
        r[64*i +: 64] = 64'd1;
      end else begin
        r[64*i +: 64] = '0;
      end
    end
    return r;
  endfunction

  assign v_sat = (in_valid_bits > FULL_BITS) ? FULL_BITS : in_valid_bits;

  assign stat.wh7      = (wh_r == 3'd7);
  assign stat.vfull    = (v_sat == FULL_BITS);
  assign stat.out_busy = out_valid_r;

  always_comb begin
    case (ctl.phase)
      stb_pkg::PH_BLOCK, stb_pkg::PH_LAST: begin
        n_sel = n_r;
        m_sel = m_r;
      end
      stb_pkg::PH_NSUM: begin
        n_sel = '0;
        m_sel = n_r;
      end
      default: begin
        n_sel = '0;
        m_sel = sig_r;
      end
    endcase
  end

  always_comb begin
    if (ctl.key0) begin
      lps_in = h_r ^ n_sel;
    end else if (ctl.kstep) begin
      lps_in = key_r ^ stb_pkg::rconst(ctl.rc);
    end else begin
      lps_in = st_r;
    end
  end

  assign lps_out = stb_pkg::lps(lps_in);

  assign n_add = (add_idx_r == 3'd0) ? {54'd0, add_len_r} : 64'd0;
  assign n_sum = {1'b0, n_r[64*add_idx_r +: 64]} + {1'b0, n_add} + {64'd0, cn_r};
  assign s_sum = {1'b0, sig_r[64*add_idx_r +: 64]} + {1'b0, m_r[64*add_idx_r +: 64]}
               + {64'd0, cs_r};

  always_comb begin
    mode_nxt      = mode_r;
    dig_mode_nxt  = dig_mode_r;
    in_msg_nxt    = in_msg_r;
    wh_nxt        = wh_r;
    add_busy_nxt  = add_busy_r;
    add_idx_nxt   = add_idx_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    m_nxt         = m_r;
    h_nxt         = h_r;
    n_nxt         = n_r;
    sig_nxt       = sig_r;
    key_nxt       = key_r;
    st_nxt        = st_r;
    dig_nxt       = dig_r;
    len_nxt       = len_r;
    add_len_nxt   = add_len_r;
    cn_nxt        = cn_r;
    cs_nxt        = cs_r;

    if (cfg_wr_en) begin
      mode_nxt = cfg_wr_data;
    end

    if (ctl.accept) begin
      in_msg_nxt = 1'b1;
      if (!in_msg_r) begin
        h_nxt   = mode_r ? {64{8'h01}} : '0;
        n_nxt   = '0;
        sig_nxt = '0;
      end
      if (!in_last_word) begin
        m_nxt[64*wh_r +: 64] = in_data_word;
        wh_nxt = wh_r + 3'd1;
      end else begin
        dig_mode_nxt = mode_r;
        wh_nxt       = '0;
        if ((wh_r == 3'd7) && (v_sat == FULL_BITS)) begin
          m_nxt[64*wh_r +: 64] = in_data_word;
        end else begin
          m_nxt   = pad_block(m_r, wh_r, v_sat, in_data_word);
          len_nxt = {1'b0, wh_r, 6'd0} + {3'd0, v_sat};
        end
      end
    end

    if (ctl.pad) begin
      m_nxt   = pad_block(m_r, 3'd0, 7'd0, 64'd0);
      len_nxt = '0;
    end

    if (ctl.key0) begin
      key_nxt = lps_out;
      st_nxt  = m_sel ^ lps_out;
    end
    if (ctl.rstep) begin
      st_nxt = lps_out;
    end
    if (ctl.kstep) begin
      key_nxt = lps_out;
      st_nxt  = st_r ^ lps_out;
    end
    if (ctl.fin) begin
      h_nxt = h_r ^ st_r ^ m_sel;
    end

    // Counter and checksum advance one 64-bit word per cycle during the rounds.
    if (ctl.add_go) begin
      add_busy_nxt = 1'b1;
      add_idx_nxt  = '0;
      cn_nxt       = 1'b0;
      cs_nxt       = 1'b0;
      add_len_nxt  = (ctl.phase == stb_pkg::PH_BLOCK) ? BLK_BITS : len_r;
    end else if (add_busy_r) begin
      n_nxt[64*add_idx_r +: 64]   = n_sum[63:0];
      sig_nxt[64*add_idx_r +: 64] = s_sum[63:0];
      cn_nxt      = n_sum[64];
      cs_nxt      = s_sum[64];
      add_idx_nxt = add_idx_r + 3'd1;
      if (add_idx_r == 3'd7) begin
        add_busy_nxt = 1'b0;
      end
    end

    if (out_valid_r && !out_stall) begin
      if (out_idx_r == 3'd7) begin
        out_valid_nxt = 1'b0;
      end else begin
        out_idx_nxt = out_idx_r + 3'd1;
      end
    end

    if (ctl.dig_load) begin
      dig_nxt       = h_r;
      out_valid_nxt = 1'b1;
      out_idx_nxt   = dig_mode_r ? 3'd4 : 3'd0;
      in_msg_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      dig_mode_r  <= 1'b0;
      in_msg_r    <= 1'b0;
      wh_r        <= '0;
      add_busy_r  <= 1'b0;
      add_idx_r   <= '0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      mode_r      <= mode_nxt;
      dig_mode_r  <= dig_mode_nxt;
      in_msg_r    <= in_msg_nxt;
      wh_r        <= wh_nxt;
      add_busy_r  <= add_busy_nxt;
      add_idx_r   <= add_idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r       <= m_nxt;
    h_r       <= h_nxt;
    n_r       <= n_nxt;
    sig_r     <= sig_nxt;
    key_r     <= key_nxt;
    st_r      <= st_nxt;
    dig_r     <= dig_nxt;
    len_r     <= len_nxt;
    add_len_r <= add_len_nxt;
    cn_r      <= cn_nxt;
    cs_r      <= cs_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = dig_r[64*out_idx_r +: 64];
  assign out_last_out    = (out_idx_r == 3'd7);

endmodule

// ===== rtl/streebog_hash_engine_unit.sv =====
// Input: a word that does not end a block is accepted while idle; the eighth word
// of a block starts a compression (one LPS step per cycle in a shared unit), and
// in_stall holds further words off until it ends. A last word takes three
// compressions (four when it fills the block) before the first digest word; the
// digest then leaves one word per cycle while out_stall is low.
// Reset: synchronous, active low; mode returns to 512-bit and no message is open.
// ----------------------------------------------------------------------------
// Streebog hash engine
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module streebog_hash_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_word,
  input  logic [6:0]  in_valid_bits,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic        out_last_out
);

  stb_pkg::ctl_t  ctl;
  stb_pkg::stat_t stat;

  stb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_word (in_last_word),
    .in_stall     (in_stall),
    .stat         (stat),
    .ctl          (ctl)
  );

  stb_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_data_word    (in_data_word),
    .in_valid_bits   (in_valid_bits),
    .in_last_word    (in_last_word),
    .ctl             (ctl),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_last_out    (out_last_out)
  );

endmodule

// ===== rtl/stb_checker.sv =====
// ----------------------------------------------------------------------------
// Streebog engine port checker
// Checks handshake and sequencing properties seen at the top level ports.
// ----------------------------------------------------------------------------
module stb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_word,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_digest_word,
  input logic        out_last_out
);

  // A stalled digest word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word)
                               && $stable(out_last_out))
    else $error("digest word changed while stalled");

  // Reset leaves no digest pending.
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("digest valid after reset");

  // The final digest word ends the digest; the next one needs a full compression.
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_out && !out_stall |=> !out_valid)
    else $error("digest continues past its last word");

  // The engine is busy after the last message word.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_word |=> in_stall)
    else $error("input taken right after last word");

endmodule

bind streebog_hash_engine_unit stb_checker u_stb_checker (.*);
